>>> design/sqw_pkg.sv
// Shared types and constants for the square wave sound channel.
// Request codes, register indexes and the duty pattern table; no dependencies.
`default_nettype none

package sqw_pkg;

  typedef logic [2:0] req_t;

  localparam req_t REQ_TICK     = 3'd0;
  localparam req_t REQ_ENVELOPE = 3'd1;
  localparam req_t REQ_LENGTH   = 3'd2;
  localparam req_t REQ_TRIGGER  = 3'd3;
  localparam req_t REQ_CLEAR    = 3'd4;
  localparam req_t REQ_LOAD     = 3'd5;

  typedef logic [2:0] reg_index_t;

  localparam reg_index_t REG_FREQUENCY       = 3'd0;
  localparam reg_index_t REG_DUTY_SELECT     = 3'd1;
  localparam reg_index_t REG_ENVELOPE_START  = 3'd2;
  localparam reg_index_t REG_ENVELOPE_RISING = 3'd3;
  localparam reg_index_t REG_ENVELOPE_PERIOD = 3'd4;
  localparam reg_index_t REG_LENGTH_COUNTING = 3'd5;

  localparam int CFG_DATA_W = 11;

  localparam logic [6:0]  LENGTH_MAX     = 7'd64;
  localparam logic [6:0]  LENGTH_ODD     = 7'd63;
  localparam logic [3:0]  ENV_DEFAULT    = 4'd8;
  localparam logic [3:0]  VOLUME_MAX     = 4'hF;
  localparam logic [11:0] PERIOD_BASE    = 12'd2048;
  localparam logic [2:0]  STEP_LAST      = 3'd7;

  // Bit 7 of each pattern is played at duty position 0.
  localparam logic [7:0] DUTY_TABLE [4] = '{8'h01, 8'h81, 8'h87, 8'h7E};

  function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] pos);
    logic [7:0] pat;
    pat = DUTY_TABLE[sel];
    return pat[3'd7 - pos];
  endfunction

endpackage

`default_nettype wire

>>> design/square_wave_sound_channel_top.sv
// Pulse sound channel: duty sequencer, period divider, volume envelope, length counter.
// Uses sqw_pkg for request codes, register indexes and the duty table.
`default_nettype none

// Takes one request per clock unless m_tready stalls the pipeline, and returns one
// result per request through the input register, then the result register, with
// the whole state update done in the single combinational pass between them. An
// empty input register takes a new request while a finished result waits on m_tready.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and should
// only change while no request is in flight. A clear request zeroes enable, duty
// position, volume, envelope count and divider bits 13:2, not length or config.
module square_wave_sound_channel_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [15:0] s_tdata,   // [2:0] sequencer_step, [9:3] length_value, rest 0
  input  wire logic [2:0]  s_tuser,   // [2:0] req_type
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [7:0]  m_tdata,   // [3:0] sample_level, [4] channel_active, rest 0
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [sqw_pkg::CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic [10:0] frequency;
  logic [1:0]  duty_select;
  logic [3:0]  envelope_start;
  logic        envelope_rising;
  logic [2:0]  envelope_period;
  logic        length_counting;

  // channel state
  logic        enabled, enabled_next;
  logic [13:0] divider_count, divider_count_next;
  logic [2:0]  duty_position, duty_position_next;
  logic [3:0]  volume_level, volume_level_next;
  logic [3:0]  envelope_count, envelope_count_next;
  logic [6:0]  length_count, length_count_next;

  // pipeline
  logic              in_v;
  sqw_pkg::req_t     in_req;
  logic [2:0]        in_step;
  logic [6:0]        in_len;
  logic              out_v;
  logic [3:0]        out_sample;
  logic              out_active;

  logic out_free;
  logic in_go;
  logic s_xfer;

  logic [13:0] reload;
  logic [13:0] dc_dec;
  logic [3:0]  env_reload;
  logic [3:0]  ec_dec;
  logic [3:0]  sample_next;
  logic        active_next;

  assign out_free = !out_v || m_tready;
  assign in_go    = in_v && out_free;
  assign s_tready = !in_v || out_free;
  assign s_xfer   = s_tvalid && s_tready;

  assign m_tvalid = out_v;
  assign m_tdata  = {3'b000, out_active, out_sample};

  always_ff @(posedge clk) begin
    if (rst) begin
      frequency       <= '0;
      duty_select     <= '0;
      envelope_start  <= '0;
      envelope_rising <= 1'b0;
      envelope_period <= '0;
      length_counting <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        sqw_pkg::REG_FREQUENCY:       frequency       <= cfg_data[10:0];
        sqw_pkg::REG_DUTY_SELECT:     duty_select     <= cfg_data[1:0];
        sqw_pkg::REG_ENVELOPE_START:  envelope_start  <= cfg_data[3:0];
        sqw_pkg::REG_ENVELOPE_RISING: envelope_rising <= cfg_data[0];
        sqw_pkg::REG_ENVELOPE_PERIOD: envelope_period <= cfg_data[2:0];
        sqw_pkg::REG_LENGTH_COUNTING: length_counting <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      in_req  <= s_tuser;
      in_step <= s_tdata[2:0];
      in_len  <= s_tdata[9:3];
    end
  end

  always_comb begin
    reload     = {12'(sqw_pkg::PERIOD_BASE - {1'b0, frequency}), 2'b00};
    dc_dec     = (divider_count != '0) ? divider_count - 14'd1 : divider_count;
    env_reload = (envelope_period == '0) ? sqw_pkg::ENV_DEFAULT : {1'b0, envelope_period};
    ec_dec     = (envelope_count != '0) ? envelope_count - 4'd1 : envelope_count;

    enabled_next        = enabled;
    divider_count_next  = divider_count;
    duty_position_next  = duty_position;
    volume_level_next   = volume_level;
    envelope_count_next = envelope_count;
    length_count_next   = length_count;

    case (in_req)
      sqw_pkg::REQ_TICK: begin
        divider_count_next = dc_dec;
        if (dc_dec == '0) begin
          duty_position_next = duty_position + 3'd1;
          divider_count_next = reload;
        end
      end
      sqw_pkg::REQ_ENVELOPE: begin
        envelope_count_next = ec_dec;
        if (ec_dec == '0) begin
          envelope_count_next = env_reload;
          // step volume, saturating at both ends
          if (envelope_period != '0) begin
            if (envelope_rising) begin
              if (volume_level != sqw_pkg::VOLUME_MAX) volume_level_next = volume_level + 4'd1;
            end else if (volume_level != '0) begin
              volume_level_next = volume_level - 4'd1;
            end
          end
        end
      end
      sqw_pkg::REQ_LENGTH: begin
        if (length_counting && length_count != '0) begin
          length_count_next = length_count - 7'd1;
          if (length_count == 7'd1) enabled_next = 1'b0;
        end
      end
      sqw_pkg::REQ_TRIGGER: begin
        enabled_next = 1'b1;
        if (length_count == '0) begin
          length_count_next = (length_counting && in_step[0]) ? sqw_pkg::LENGTH_ODD
                                                              : sqw_pkg::LENGTH_MAX;
        end
        divider_count_next  = reload;
        volume_level_next   = envelope_start;
        envelope_count_next = env_reload + {3'b000, in_step == sqw_pkg::STEP_LAST};
      end
      sqw_pkg::REQ_CLEAR: begin
        enabled_next        = 1'b0;
        duty_position_next  = '0;
        volume_level_next   = '0;
        envelope_count_next = '0;
        divider_count_next  = {12'd0, divider_count[1:0]};
      end
      sqw_pkg::REQ_LOAD: begin
        length_count_next = (in_len > sqw_pkg::LENGTH_MAX) ? sqw_pkg::LENGTH_MAX : in_len;
      end
      default: ;
    endcase

    sample_next = (enabled_next && sqw_pkg::duty_bit(duty_select, duty_position_next))
                  ? volume_level_next : 4'd0;
    active_next = enabled_next && (envelope_start != '0 || envelope_rising);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled        <= 1'b0;
      divider_count  <= '0;
      duty_position  <= '0;
      volume_level   <= '0;
      envelope_count <= '0;
      length_count   <= '0;
    end else if (in_go) begin
      enabled        <= enabled_next;
      divider_count  <= divider_count_next;
      duty_position  <= duty_position_next;
      volume_level   <= volume_level_next;
      envelope_count <= envelope_count_next;
      length_count   <= length_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (out_free) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      out_sample <= sample_next;
      out_active <= active_next;
    end
  end

  // checks on the channel state
  a_env_range: assert property (@(posedge clk) disable iff (rst)
    envelope_count <= 4'd9)
    else $error("envelope count out of range");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    length_count <= sqw_pkg::LENGTH_MAX)
    else $error("length count out of range");

  a_div_range: assert property (@(posedge clk) disable iff (rst)
    divider_count <= 14'd8192)
    else $error("divider count out of range");

  a_clear_off: assert property (@(posedge clk) disable iff (rst)
    (in_go && in_req == sqw_pkg::REQ_CLEAR) |=> (!enabled && volume_level == '0))
    else $error("clear left channel running");

  a_silent_off: assert property (@(posedge clk) disable iff (rst)
    (in_go && !enabled_next) |=> (out_sample == '0 && !out_active))
    else $error("disabled channel produced output");

endmodule

`default_nettype wire
